@@ rtl/aabb_frustum_cull_assert.svh @@
// Assertion macros shared by the culling RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef AABB_FRUSTUM_CULL_ASSERT_SVH
`define AABB_FRUSTUM_CULL_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define AFC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aabb_frustum_cull: assertion failed");

// Next-cycle implication, disabled while rst is high.
`define AFC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aabb_frustum_cull: assertion failed");

`endif

@@ rtl/afc_pkg.sv @@
// Shared constants and types of the box culling block.
// Depends on nothing; used by the channel interfaces and the top level.
package afc_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int COEF_BITS_DEFAULT  = 16;
   localparam int CSR_DATA_BITS      = 64;
   localparam int NUM_ROWS           = 4;
   localparam int NUM_AXES           = 3;
   localparam int NUM_CORNERS        = 8;
   // Fraction bits of a coordinate; w = 1.0 is 1 shifted left by this.
   localparam int W_ONE_SHIFT        = 4;

   typedef enum logic [1:0] {
      REG_MATRIX_ROW0 = 2'd0,
      REG_MATRIX_ROW1 = 2'd1,
      REG_MATRIX_ROW2 = 2'd2,
      REG_MATRIX_ROW3 = 2'd3
   } csr_index_type;

endpackage

@@ rtl/afc_if.sv @@
// Valid/ready channel interfaces of the box culling block: box request,
// visibility response and register write. Depends on afc_pkg.
interface afc_req_if #(
   parameter int COORD_BITS = afc_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         has_bounds;
   logic signed [COORD_BITS-1:0] min_x;
   logic signed [COORD_BITS-1:0] min_y;
   logic signed [COORD_BITS-1:0] min_z;
   logic signed [COORD_BITS-1:0] max_x;
   logic signed [COORD_BITS-1:0] max_y;
   logic signed [COORD_BITS-1:0] max_z;

   modport source (output valid, has_bounds, min_x, min_y, min_z, max_x, max_y, max_z,
                   input ready);
   modport sink   (input valid, has_bounds, min_x, min_y, min_z, max_x, max_y, max_z,
                   output ready);
endinterface

interface afc_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink   (input valid, visible, output ready);
endinterface

interface afc_csr_if;
   logic                               valid;
   logic                               ready;
   afc_pkg::csr_index_type             index;
   logic [afc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/aabb_frustum_cull.sv @@
// Top level of the axis-aligned box frustum culling block.
// Depends on afc_pkg, the channel interfaces in afc_if.sv and the assertion header.
//
// The block takes one box per request transfer and returns one visibility flag per
// response transfer, in order. It accepts a new box in every cycle while the response
// side does not stall, so the sustained rate is one box per clock. The products
// register at the request transfer edge; the clip sums, the cull decision and the
// response register follow in that order. The clock period is set by
// the multiplier stage: all 24 coefficient-by-coordinate products of a box (four
// matrix rows times three axes times the min and max value) are formed in parallel
// in the first stage. The second stage sums them into the clip-space x, y, z and w
// of all eight corners, and the third stage runs the six plane tests and reduces
// them to a single cull decision. Any stage holds its box while the one after it is
// full and stalled, so a slow consumer costs no data; with the response held, the
// three inner stages still take up to three more boxes. A box whose has_bounds flag
// is clear is always reported visible. The transform sits in four 64-bit registers,
// one row each, with four signed Q4.12 entries per row (column 0 in the low bits);
// coordinates are signed Q12.4, and all arithmetic is exact. Registers reset to zero,
// which makes every box visible, and must be written only while no box is in flight.
`include "aabb_frustum_cull_assert.svh"

module aabb_frustum_cull #(
   parameter int COORD_BITS = afc_pkg::COORD_BITS_DEFAULT,
   parameter int COEF_BITS  = afc_pkg::COEF_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   afc_req_if.sink   req_bus,
   afc_rsp_if.source rsp_bus,
   afc_csr_if.sink   csr_bus
);

   localparam int ROWS      = afc_pkg::NUM_ROWS;
   localparam int AXES      = afc_pkg::NUM_AXES;
   localparam int CORNERS   = afc_pkg::NUM_CORNERS;
   localparam int DATA_BITS = afc_pkg::CSR_DATA_BITS;
   // A product of one coefficient and one coordinate is exact in this width.
   localparam int PROD_BITS = COEF_BITS + COORD_BITS;
   // Three products plus the w term of the column for w = 1.0.
   localparam int CLIP_BITS = PROD_BITS + 2;
   // Clip value plus or minus w.
   localparam int TEST_BITS = CLIP_BITS + 1;
   // Rows are read through a zero-extended window so that entries past bit 63 read 0.
   localparam int EXT_BITS  = (ROWS * COEF_BITS > DATA_BITS) ? ROWS * COEF_BITS : DATA_BITS;

   // Transform registers.
   logic [DATA_BITS-1:0]        row_ff [ROWS];
   logic signed [COEF_BITS-1:0] coef   [ROWS][ROWS];

   // Stage 1: products, index [row][axis][0 = min, 1 = max].
   logic                        valid1_ff;
   logic                        bounds1_ff;
   logic signed [PROD_BITS-1:0] prod1_ff [ROWS][AXES][2];
   logic signed [PROD_BITS-1:0] prod1_in [ROWS][AXES][2];

   // Stage 2: clip-space coordinates, index [corner][row].
   logic                        valid2_ff;
   logic                        bounds2_ff;
   logic signed [CLIP_BITS-1:0] clip2_ff [CORNERS][ROWS];
   logic signed [CLIP_BITS-1:0] clip2_in [CORNERS][ROWS];

   // Stage 3: cull decision.
   logic                        valid3_ff;
   logic                        bounds3_ff;
   logic                        culled3_ff;
   logic                        culled3_in;

   // Response register.
   logic                        rsp_valid_ff;
   logic                        rsp_visible_ff;

   logic                        ready1;
   logic                        ready2;
   logic                        ready3;
   logic                        rsp_load;

   // ---------------------------------------------------------------------------------
   // Register writes. Every index names a row, so every write lands.
   // ---------------------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            row_ff[r] <= '0;
         end
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            afc_pkg::REG_MATRIX_ROW0: row_ff[0] <= csr_bus.data;
            afc_pkg::REG_MATRIX_ROW1: row_ff[1] <= csr_bus.data;
            afc_pkg::REG_MATRIX_ROW2: row_ff[2] <= csr_bus.data;
            afc_pkg::REG_MATRIX_ROW3: row_ff[3] <= csr_bus.data;
         endcase
      end
   end

   always_comb begin
      logic [EXT_BITS-1:0] ext;
      for (int r = 0; r < ROWS; r++) begin
         ext = EXT_BITS'(row_ff[r]);
         for (int c = 0; c < ROWS; c++) begin
            coef[r][c] = ext[c*COEF_BITS +: COEF_BITS];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Flow control: a stage takes a new box when it is empty or its box moves on.
   // ---------------------------------------------------------------------------------
   assign rsp_load      = valid3_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign ready3        = !valid3_ff || !rsp_valid_ff || rsp_bus.ready;
   assign ready2        = !valid2_ff || ready3;
   assign ready1        = !valid1_ff || ready2;
   assign req_bus.ready = ready1;

   // ---------------------------------------------------------------------------------
   // Stage 1: every row coefficient of an axis times that axis's min and max.
   // ---------------------------------------------------------------------------------
   always_comb begin
      logic signed [COORD_BITS-1:0] lo [AXES];
      logic signed [COORD_BITS-1:0] hi [AXES];
      lo[0] = req_bus.min_x;
      lo[1] = req_bus.min_y;
      lo[2] = req_bus.min_z;
      hi[0] = req_bus.max_x;
      hi[1] = req_bus.max_y;
      hi[2] = req_bus.max_z;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < AXES; c++) begin
            prod1_in[r][c][0] = PROD_BITS'(coef[r][c]) * PROD_BITS'(lo[c]);
            prod1_in[r][c][1] = PROD_BITS'(coef[r][c]) * PROD_BITS'(hi[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (ready1) begin
         valid1_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_bus.valid) begin
         bounds1_ff <= req_bus.has_bounds;
         prod1_ff   <= prod1_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: corner k takes max on axis a when bit a of k is set, min otherwise.
   // The fourth column multiplies w = 1.0, which is a plain shift.
   // ---------------------------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < CORNERS; k++) begin
         for (int r = 0; r < ROWS; r++) begin
            clip2_in[k][r] =
               CLIP_BITS'(((k & 1) != 0) ? prod1_ff[r][0][1] : prod1_ff[r][0][0]) +
               CLIP_BITS'(((k & 2) != 0) ? prod1_ff[r][1][1] : prod1_ff[r][1][0]) +
               CLIP_BITS'(((k & 4) != 0) ? prod1_ff[r][2][1] : prod1_ff[r][2][0]) +
               (CLIP_BITS'(coef[r][3]) <<< afc_pkg::W_ONE_SHIFT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (ready2) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && valid1_ff) begin
         bounds2_ff <= bounds1_ff;
         clip2_ff   <= clip2_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 3: a plane culls the box when all eight corners lie strictly beyond it.
   // The low plane of an axis needs a + w < 0, the high plane a - w > 0.
   // ---------------------------------------------------------------------------------
   always_comb begin
      logic signed [TEST_BITS-1:0] plus;
      logic signed [TEST_BITS-1:0] minus;
      logic                        all_lo;
      logic                        all_hi;
      culled3_in = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         all_lo = 1'b1;
         all_hi = 1'b1;
         for (int k = 0; k < CORNERS; k++) begin
            plus   = TEST_BITS'(clip2_ff[k][a]) + TEST_BITS'(clip2_ff[k][3]);
            minus  = TEST_BITS'(clip2_ff[k][a]) - TEST_BITS'(clip2_ff[k][3]);
            all_lo = all_lo && plus[TEST_BITS-1];
            all_hi = all_hi && !minus[TEST_BITS-1] && (minus != '0);
         end
         culled3_in = culled3_in || all_lo || all_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (ready3) begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && valid2_ff) begin
         bounds3_ff <= bounds2_ff;
         culled3_ff <= culled3_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Response register. A box without bounds is visible whatever the planes say.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_visible_ff <= !bounds3_ff || !culled3_ff;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.visible = rsp_visible_ff;

   // ---------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------
   `AFC_ASSERT_NXT(a_nobounds_visible, clock, reset, rsp_load && !bounds3_ff, rsp_visible_ff)
   `AFC_ASSERT_NXT(a_stage1_holds, clock, reset, valid1_ff && !ready2, valid1_ff)
   `AFC_ASSERT_NXT(a_stage2_holds, clock, reset, valid2_ff && !ready3, valid2_ff)
   `AFC_ASSERT_NXT(a_reset_empties, clock, 1'b0, reset,
                   !valid1_ff && !valid2_ff && !valid3_ff && !rsp_valid_ff)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for aabb_frustum_cull: directed boxes, then random boxes
// under random transforms, checked against a behavioral visibility predictor.
// Depends on afc_pkg, the channel interfaces in afc_if.sv and the block itself.
module tb_top;

   localparam int COORD_BITS  = afc_pkg::COORD_BITS_DEFAULT;
   localparam int COEF_BITS   = afc_pkg::COEF_BITS_DEFAULT;
   // Cycles from a request transfer to the response register.
   localparam int PIPE_DEPTH  = 3;
   localparam int RANDOM_PHASES   = 7;
   localparam int BOXES_PER_PHASE = 250;
   // The slowest correct run stays well inside this limit, even when each box meets a
   // sender gap, a response stall and the pipeline.
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   localparam logic signed [COORD_BITS-1:0] C_MIN = 16'sh8000;
   localparam logic signed [COORD_BITS-1:0] C_MAX = 16'sh7FFF;

   typedef logic [afc_pkg::NUM_ROWS-1:0][afc_pkg::CSR_DATA_BITS-1:0] xform_type;

   typedef struct packed {
      logic                         has_bounds;
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] min_z;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] max_y;
      logic signed [COORD_BITS-1:0] max_z;
   } box_type;

   // Transform to load before a directed box, if any.
   typedef enum logic [2:0] {
      KEEP_XFORM,
      LOAD_IDENTITY,
      LOAD_MOST_NEG,
      LOAD_MOST_POS,
      LOAD_MINUS_LSB,
      LOAD_ZERO
   } xform_load_type;

   typedef struct packed {
      xform_load_type load;
      box_type        box;
      logic           known;    // visible column below holds the answer
      logic           visible;
   } plan_row_type;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_SPOTTY,
      DRAIN_STALLS
   } drain_mode_type;

   localparam xform_type IDENTITY = {
      64'h1000_0000_0000_0000,
      64'h0000_1000_0000_0000,
      64'h0000_0000_1000_0000,
      64'h0000_0000_0000_1000
   };

   // Directed boxes. With the identity transform w is 1.0, which is 16 in the
   // coordinate format, so the clip volume is -16..16 on every axis.
   localparam plan_row_type PLAN [25] = '{
      // Zero transform after reset: every box is visible.
      '{KEEP_XFORM, '{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b1},
      '{KEEP_XFORM, '{1'b1, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 1'b1, 1'b1},
      '{KEEP_XFORM, '{1'b1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b1, 1'b1},
      '{KEEP_XFORM, '{1'b1, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN}, 1'b1, 1'b1},
      // Identity: one box inside, then one box past each of the six planes.
      '{LOAD_IDENTITY, '{1'b1, -16'sd8, -16'sd8, -16'sd8, 16'sd8, 16'sd8, 16'sd8},
        1'b1, 1'b1},
      '{KEEP_XFORM, '{1'b1, 16'sd32, -16'sd8, -16'sd8, 16'sd100, 16'sd8, 16'sd8},
        1'b1, 1'b0},
      '{KEEP_XFORM, '{1'b1, -16'sd100, -16'sd8, -16'sd8, -16'sd32, 16'sd8, 16'sd8},
        1'b1, 1'b0},
      '{KEEP_XFORM, '{1'b1, -16'sd8, 16'sd32, -16'sd8, 16'sd8, 16'sd100, 16'sd8},
        1'b1, 1'b0},
      '{KEEP_XFORM, '{1'b1, -16'sd8, -16'sd100, -16'sd8, 16'sd8, -16'sd32, 16'sd8},
        1'b1, 1'b0},
      '{KEEP_XFORM, '{1'b1, -16'sd8, -16'sd8, 16'sd32, 16'sd8, 16'sd8, 16'sd100},
        1'b1, 1'b0},
      '{KEEP_XFORM, '{1'b1, -16'sd8, -16'sd8, -16'sd100, 16'sd8, 16'sd8, -16'sd32},
        1'b1, 1'b0},
      // A box lying exactly on a plane is not strictly beyond it.
      '{KEEP_XFORM, '{1'b1, 16'sd16, -16'sd8, -16'sd8, 16'sd16, 16'sd8, 16'sd8},
        1'b1, 1'b1},
      '{KEEP_XFORM, '{1'b1, 16'sd17, -16'sd8, -16'sd8, 16'sd17, 16'sd8, 16'sd8},
        1'b1, 1'b0},
      '{KEEP_XFORM, '{1'b1, -16'sd8, -16'sd8, -16'sd16, 16'sd8, 16'sd8, -16'sd16},
        1'b1, 1'b1},
      '{KEEP_XFORM, '{1'b1, -16'sd8, -16'sd8, -16'sd17, 16'sd8, 16'sd8, -16'sd17},
        1'b1, 1'b0},
      // Without bounds the corners are ignored.
      '{KEEP_XFORM, '{1'b0, 16'sd32, 16'sd32, 16'sd32, 16'sd100, 16'sd100, 16'sd100},
        1'b1, 1'b1},
      // Inverted boxes are used as given.
      '{KEEP_XFORM, '{1'b1, 16'sd100, -16'sd8, -16'sd8, 16'sd32, 16'sd8, 16'sd8},
        1'b1, 1'b0},
      '{KEEP_XFORM, '{1'b1, 16'sd8, 16'sd8, 16'sd8, -16'sd8, -16'sd8, -16'sd8},
        1'b1, 1'b1},
      '{KEEP_XFORM, '{1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}, 1'b1, 1'b1},
      '{KEEP_XFORM, '{1'b1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b1, 1'b0},
      // Extreme coefficients; the predictor decides these.
      '{LOAD_MOST_NEG, '{1'b1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b0, 1'b0},
      '{KEEP_XFORM, '{1'b1, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 1'b0, 1'b0},
      '{LOAD_MOST_POS, '{1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}, 1'b0, 1'b0},
      '{LOAD_MINUS_LSB, '{1'b1, -16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1},
        1'b0, 1'b0},
      // Back to an explicitly written zero transform.
      '{LOAD_ZERO, '{1'b1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b1, 1'b1}
   };

   logic clock = 1'b0;
   logic reset;

   afc_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   afc_rsp_if rsp_bus ();
   afc_csr_if csr_bus ();

   aabb_frustum_cull #(
      .COORD_BITS(COORD_BITS),
      .COEF_BITS (COEF_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #2 clock = ~clock;

   // Copy of the transform as the block should hold it, kept in step with
   // every register write transfer.
   xform_type transform_rows = '0;

   // Visibility flags still owed by the block, oldest first.
   logic pending_visible [$];

   int mismatches   = 0;
   int results_seen = 0;
   int cycle_count  = 0;

   // Sender burst state: when gaps are on, a burst of transfers is followed
   // by a random idle stretch.
   bit gaps_on     = 1'b1;
   int burst_left  = 0;

   // Predicts the visibility flag of one box under a given transform. Clip
   // values are exact 64-bit sums, so every comparison is made at full
   // precision; a plane culls only when all eight corners are strictly past it.
   function automatic logic box_visible(box_type b, xform_type t);
      longint m [afc_pkg::NUM_ROWS][afc_pkg::NUM_ROWS];
      longint lo [afc_pkg::NUM_AXES];
      longint hi [afc_pkg::NUM_AXES];
      longint v [afc_pkg::NUM_ROWS];
      longint clip_a;
      longint clip_w;
      logic [afc_pkg::NUM_AXES-1:0] past_lo;
      logic [afc_pkg::NUM_AXES-1:0] past_hi;
      if (!b.has_bounds) begin
         return 1'b1;
      end
      for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
         for (int c = 0; c < afc_pkg::NUM_ROWS; c++) begin
            m[r][c] = $signed(t[r][c*COEF_BITS +: COEF_BITS]);
         end
      end
      lo[0] = b.min_x;
      lo[1] = b.min_y;
      lo[2] = b.min_z;
      hi[0] = b.max_x;
      hi[1] = b.max_y;
      hi[2] = b.max_z;
      past_lo = '1;
      past_hi = '1;
      for (int k = 0; k < afc_pkg::NUM_CORNERS; k++) begin
         for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
            v[a] = k[a] ? hi[a] : lo[a];
         end
         v[afc_pkg::NUM_ROWS-1] = longint'(1) << afc_pkg::W_ONE_SHIFT;
         for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
            clip_a = 0;
            clip_w = 0;
            for (int c = 0; c < afc_pkg::NUM_ROWS; c++) begin
               clip_a += m[a][c] * v[c];
               clip_w += m[afc_pkg::NUM_ROWS-1][c] * v[c];
            end
            if (clip_a + clip_w >= 0) past_lo[a] = 1'b0;
            if (clip_a - clip_w <= 0) past_hi[a] = 1'b0;
         end
      end
      return !((|past_lo) || (|past_hi));
   endfunction

   // Presents one box and waits for its transfer. The expectation is queued at
   // the accepting edge, from the table when it is given there, otherwise from
   // the predictor under the transform currently loaded.
   task automatic send_box(input box_type b, input logic known, input logic table_visible);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.has_bounds <= b.has_bounds;
      req_bus.min_x      <= b.min_x;
      req_bus.min_y      <= b.min_y;
      req_bus.min_z      <= b.min_z;
      req_bus.max_x      <= b.max_x;
      req_bus.max_y      <= b.max_y;
      req_bus.max_z      <= b.max_z;
      do @(posedge clock); while (!req_bus.ready);
      pending_visible.push_back(known ? table_visible : box_visible(b, transform_rows));
      if (burst_left > 0) burst_left--;
   endtask

   // Stops sending and waits until every owed result has been transferred.
   // Every box yields exactly one result, so the block is then idle.
   task automatic drain_boxes();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_visible.size() != 0) @(posedge clock);
   endtask

   // Writes all four transform rows, one register transfer each. Only called
   // with the block drained.
   task automatic load_transform(input xform_type t);
      afc_pkg::csr_index_type idx;
      idx = idx.first();
      repeat (afc_pkg::NUM_ROWS) begin
         @(negedge clock);
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx;
         csr_bus.data  <= t[idx];
         do @(posedge clock); while (!csr_bus.ready);
         transform_rows[idx] = t[idx];
         idx = idx.next();
      end
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Response side: stalls follow a pattern of their own that switches at random
   // intervals between always ready, scattered stalls and occasional long stalls.
   initial begin : rsp_stall_pattern
      drain_mode_type mode;
      int             mode_left;
      int             stall_left;
      mode       = DRAIN_FREE;
      mode_left  = 0;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = drain_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 400);
         end
         mode_left--;
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               DRAIN_FREE: begin
                  rsp_bus.ready <= 1'b1;
               end
               DRAIN_SPOTTY: begin
                  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  if ($urandom_range(0, 11) == 0) begin
                     stall_left = $urandom_range(3, 15);
                     rsp_bus.ready <= 1'b0;
                  end else begin
                     rsp_bus.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Response checker: each response transfer is matched against the oldest
   // owed flag. Only the first few failures are printed.
   always @(posedge clock) begin : visible_check
      logic want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_visible.size() == 0) begin
            if (mismatches < MAX_REPORTS) begin
               $display("tb_top: response %0d arrived with no box outstanding",
                        results_seen);
            end
            mismatches++;
         end else begin
            want = pending_visible.pop_front();
            if (rsp_bus.visible !== want) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("tb_top: response %0d visible expected %b got %b",
                           results_seen, want, rsp_bus.visible);
               end
               mismatches++;
            end
         end
         results_seen++;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: errors");
      $finish;
   end

   initial begin : stimulus
      xform_type next_xform;
      box_type   b;
      int        coef_v [afc_pkg::NUM_ROWS][afc_pkg::NUM_ROWS];
      int        lo_v [afc_pkg::NUM_AXES];
      int        hi_v [afc_pkg::NUM_AXES];
      int        centre;
      int        half;
      int        span;
      int        scale;
      int        swap_v;
      int        style;

      // Every input is known from time zero, while reset is held.
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.has_bounds = 1'b0;
      req_bus.min_x      = '0;
      req_bus.min_y      = '0;
      req_bus.min_z      = '0;
      req_bus.max_x      = '0;
      req_bus.max_y      = '0;
      req_bus.max_z      = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = afc_pkg::REG_MATRIX_ROW0;
      csr_bus.data       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Transform changes only happen with nothing in flight.
      foreach (PLAN[i]) begin
         if (PLAN[i].load != KEEP_XFORM) begin
            drain_boxes();
            case (PLAN[i].load)
               LOAD_IDENTITY:  next_xform = IDENTITY;
               LOAD_MOST_NEG:  next_xform = {afc_pkg::NUM_ROWS{64'h8000_8000_8000_8000}};
               LOAD_MOST_POS:  next_xform = {afc_pkg::NUM_ROWS{64'h7FFF_7FFF_7FFF_7FFF}};
               LOAD_MINUS_LSB: next_xform = '1;
               default:        next_xform = '0;
            endcase
            load_transform(next_xform);
         end
         send_box(PLAN[i].box, PLAN[i].known, PLAN[i].visible);
      end

      // Random part: each phase loads a fresh transform and sends a run of
      // boxes. Every third phase keeps the sender gapless.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_boxes();
         for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < afc_pkg::NUM_ROWS; c++) begin
               coef_v[r][c] = 0;
            end
         end
         // The first phase always uses a fully random transform so that every
         // register bit toggles; later phases mostly use camera-like shapes
         // where both culled and visible boxes are common.
         style = (phase == 0) ? 0 : $urandom_range(0, 3);
         case (style)
            0: begin
               for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
                  for (int c = 0; c < afc_pkg::NUM_ROWS; c++) begin
                     coef_v[r][c] = int'($urandom_range(0, 65535)) - 32768;
                  end
               end
            end
            1: begin
               // Scale and translate with w fixed at 1.0.
               for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
                  scale = $urandom_range(256, 8192);
                  coef_v[a][a] = $urandom_range(0, 1) ? -scale : scale;
                  coef_v[a][afc_pkg::NUM_ROWS-1] = int'($urandom_range(0, 32768)) - 16384;
               end
               coef_v[afc_pkg::NUM_ROWS-1][afc_pkg::NUM_ROWS-1] = 4096;
            end
            2: begin
               // Identity with small disturbances everywhere, w row included.
               for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
                  for (int c = 0; c < afc_pkg::NUM_ROWS; c++) begin
                     coef_v[r][c] = ((r == c) ? 4096 : 0) + int'($urandom_range(0, 1023)) - 512;
                  end
               end
            end
            default: begin
               // Perspective projection looking down negative z.
               coef_v[0][0] = $urandom_range(1024, 8192);
               coef_v[1][1] = $urandom_range(1024, 8192);
               coef_v[2][2] = -int'($urandom_range(4096, 8192));
               coef_v[2][3] = -int'($urandom_range(0, 16384));
               coef_v[3][2] = -4096;
            end
         endcase
         for (int r = 0; r < afc_pkg::NUM_ROWS; r++) begin
            for (int c = 0; c < afc_pkg::NUM_ROWS; c++) begin
               next_xform[r][c*COEF_BITS +: COEF_BITS] = coef_v[r][c][COEF_BITS-1:0];
            end
         end
         load_transform(next_xform);

         gaps_on    = (phase % 3 != 1);
         burst_left = 0;
         for (int n = 0; n < BOXES_PER_PHASE; n++) begin
            if ($urandom_range(0, 7) == 0) begin
               // Raw random fields reach every bit and every corner order.
               b = box_type'({$urandom, $urandom, $urandom, $urandom});
            end else begin
               // A box of random size around a random centre; most stay near
               // the clip volume so that both outcomes occur often.
               case ($urandom_range(0, 3))
                  0:       span = 32;
                  1:       span = 128;
                  2:       span = 1024;
                  default: span = 32767;
               endcase
               for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
                  centre = int'($urandom_range(0, 2 * span)) - span;
                  half   = $urandom_range(0, span / 2);
                  lo_v[a] = centre - half;
                  hi_v[a] = centre + half;
                  if (lo_v[a] < -32768) lo_v[a] = -32768;
                  if (hi_v[a] > 32767) hi_v[a] = 32767;
                  if ($urandom_range(0, 15) == 0) begin
                     swap_v  = lo_v[a];
                     lo_v[a] = hi_v[a];
                     hi_v[a] = swap_v;
                  end
               end
               b.has_bounds = ($urandom_range(0, 9) != 0);
               b.min_x = lo_v[0][COORD_BITS-1:0];
               b.min_y = lo_v[1][COORD_BITS-1:0];
               b.min_z = lo_v[2][COORD_BITS-1:0];
               b.max_x = hi_v[0][COORD_BITS-1:0];
               b.max_y = hi_v[1][COORD_BITS-1:0];
               b.max_z = hi_v[2][COORD_BITS-1:0];
            end
            send_box(b, 1'b0, 1'b0);
            // Now and then the sender holds off until the pipeline is empty.
            if ($urandom_range(0, 149) == 0) drain_boxes();
         end
      end

      // Wait for the last results, then give the pipeline time to show any
      // stray response before deciding.
      drain_boxes();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (mismatches == 0 && pending_visible.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
